// File: rtl/modbus_coil_reply_checker_macros.svh
// ----------------------------------------------------------------------------
// modbus_coil_reply_checker_macros.svh
// assertion helpers used by the reply checker queue
// ----------------------------------------------------------------------------
`ifndef MODBUS_COIL_REPLY_CHECKER_MACROS_SVH
`define MODBUS_COIL_REPLY_CHECKER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MCRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the next cycle
`define MCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mcrc_pkg.sv
// ----------------------------------------------------------------------------
// mcrc_pkg
// types, constants and crc helper of the modbus read-coils reply checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcrc_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  FC_READ_COILS = 8'h01;
    localparam logic [9:0]  MIN_FRAME     = 10'd5;
    localparam logic [8:0]  POS_LIMIT     = 9'd511;
    localparam logic [9:0]  HDR_BYTES     = 10'd3;
    localparam int          Q_DEPTH       = 2;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_SLAVE_ADDRESS = 1'b0,
        CFG_COILS_IN_USE  = 1'b1
    } cfg_index_t;

    // frame status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_WRONG_SLV = 3'd2,
        ST_WRONG_FC  = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_CRC_ERR   = 3'd5
    } status_t;

    // role of one byte inside the frame
    typedef enum logic [3:0] {
        KIND_ADDR,
        KIND_FUNC,
        KIND_COUNT,
        KIND_DATA,
        KIND_COIL_LO,
        KIND_COIL_HI,
        KIND_CRC_LO,
        KIND_CRC_HI,
        KIND_SKIP
    } kind_t;

    // classified byte travelling from front to back
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       bad;
        logic       last;
        logic       is_short;
        logic       is_trunc;
    } q_entry_t;

    // one byte through crc-16, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/mcrc_byte_if.sv
// ----------------------------------------------------------------------------
// mcrc_byte_if
// valid/ready channel carrying reply frame bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mcrc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// File: rtl/mcrc_result_if.sv
// ----------------------------------------------------------------------------
// mcrc_result_if
// valid/ready channel carrying one check result per frame
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mcrc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_status;
    logic [15:0] coil_states;

    modport source (output valid, output frame_status, output coil_states, input ready);
    modport sink   (input valid, input frame_status, input coil_states, output ready);
endinterface

// File: rtl/mcrc_front.sv
// ----------------------------------------------------------------------------
// mcrc_front
// tracks byte position and byte count, classifies each incoming byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcrc_front
    import mcrc_pkg::*;
#(
    parameter int COIL_W = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      slave_address,
    mcrc_byte_if.sink       byte_stream,
    input  logic            q_ready,
    output logic            push,
    output q_entry_t        entry
);

    logic [8:0] pos_reg, pos_next;
    logic [7:0] count_reg, count_next;
    logic [9:0] p_ext;
    logic [9:0] crc_pos;
    logic [9:0] data_idx;
    logic [9:0] frame_len;

    assign byte_stream.ready = q_ready;
    assign push = byte_stream.valid && q_ready;

    assign p_ext     = {1'b0, pos_reg};
    assign crc_pos   = HDR_BYTES + {2'b00, count_reg};
    assign data_idx  = p_ext - HDR_BYTES;
    assign frame_len = p_ext + 10'd1;

    // classify the byte at the current position
    always_comb begin
        entry.data     = byte_stream.frame_byte;
        entry.last     = byte_stream.frame_end;
        entry.bad      = 1'b0;
        entry.is_short = frame_len < MIN_FRAME;
        entry.is_trunc = frame_len < (MIN_FRAME + {2'b00, count_reg});
        priority if (pos_reg == 9'd0) begin
            entry.kind = KIND_ADDR;
            entry.bad  = byte_stream.frame_byte != slave_address;
        end
        else if (pos_reg == 9'd1) begin
            entry.kind = KIND_FUNC;
            entry.bad  = byte_stream.frame_byte != FC_READ_COILS;
        end
        else if (pos_reg == 9'd2) begin
            entry.kind = KIND_COUNT;
        end
        else if (p_ext < crc_pos) begin
            if (data_idx == 10'd0) begin
                entry.kind = KIND_COIL_LO;
            end
            else if (data_idx == 10'd1 && COIL_W > 8) begin
                entry.kind = KIND_COIL_HI;
            end
            else begin
                entry.kind = KIND_DATA;
            end
        end
        else if (p_ext == crc_pos) begin
            entry.kind = KIND_CRC_LO;
        end
        else if (p_ext == crc_pos + 10'd1) begin
            entry.kind = KIND_CRC_HI;
        end
        else begin
            entry.kind = KIND_SKIP;
        end
    end

    // position and byte count, cleared at the end of each frame
    always_comb begin
        pos_next   = pos_reg;
        count_next = count_reg;
        if (push) begin
            if (byte_stream.frame_end) begin
                pos_next   = '0;
                count_next = '0;
            end
            else begin
                if (pos_reg < POS_LIMIT) begin
                    pos_next = pos_reg + 9'd1;
                end
                if (pos_reg == 9'd2) begin
                    count_next = byte_stream.frame_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/mcrc_queue.sv
// ----------------------------------------------------------------------------
// mcrc_queue
// two-entry fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modbus_coil_reply_checker_macros.svh"

module mcrc_queue
    import mcrc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     not_full,
    input  logic     pop,
    output logic     not_empty,
    output q_entry_t head
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    q_entry_t        slots_reg [Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign not_full  = count_reg != CW'(Q_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = slots_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `MCRC_ASSERT(a_count_bound, count_reg <= CW'(Q_DEPTH), "queue fill count out of range")
    `MCRC_ASSERT(a_no_pop_empty, !(pop && count_reg == '0), "pop from empty queue")
    `MCRC_ASSERT_NEXT(a_fill_grows, push && !pop, count_reg == $past(count_reg) + CW'(1), "push lost")

endmodule

// File: rtl/mcrc_back.sv
// ----------------------------------------------------------------------------
// mcrc_back
// runs crc, captures trailing crc and coils, produces the frame result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcrc_back
    import mcrc_pkg::*;
#(
    parameter int COIL_W = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [4:0]  coils_in_use,
    input  logic        q_valid,
    input  q_entry_t    head,
    output logic        pop,
    mcrc_result_if.source result
);

    logic [15:0]       crc_reg, crc_next;
    logic [15:0]       rcrc_reg, rcrc_next;
    logic [COIL_W-1:0] coils_reg, coils_next;
    logic              slave_bad_reg, slave_bad_next;
    logic              func_bad_reg, func_bad_next;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic [15:0]       states_reg, states_next;
    logic [15:0]       coil_ins;
    logic [4:0]        coil_n;
    logic [15:0]       coil_mask;
    logic [15:0]       coils_wide;

    assign result.valid        = out_valid_reg;
    assign result.frame_status = status_reg;
    assign result.coil_states  = states_reg;

    // a final byte waits until the result register is free
    assign pop = q_valid && (!head.last || !out_valid_reg || result.ready);

    // coil count clamped to the stored coil width
    assign coil_n     = (coils_in_use > 5'(COIL_W)) ? 5'(COIL_W) : coils_in_use;
    assign coils_wide = 16'(coils_reg);
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            coil_mask[i] = 5'(i) < coil_n;
        end
    end

    // per-byte frame state update
    always_comb begin
        crc_next       = crc_reg;
        rcrc_next      = rcrc_reg;
        coils_next     = coils_reg;
        slave_bad_next = slave_bad_reg;
        func_bad_next  = func_bad_reg;
        coil_ins       = '0;
        unique case (head.kind)
            KIND_ADDR:
            begin
                slave_bad_next = head.bad;
                crc_next       = crc16_byte(crc_reg, head.data);
            end
            KIND_FUNC:
            begin
                func_bad_next = head.bad;
                crc_next      = crc16_byte(crc_reg, head.data);
            end
            KIND_COUNT, KIND_DATA:
            begin
                crc_next = crc16_byte(crc_reg, head.data);
            end
            KIND_COIL_LO:
            begin
                crc_next   = crc16_byte(crc_reg, head.data);
                coil_ins   = {8'h00, head.data};
                coils_next = coils_reg | coil_ins[COIL_W-1:0];
            end
            KIND_COIL_HI:
            begin
                crc_next   = crc16_byte(crc_reg, head.data);
                coil_ins   = {head.data, 8'h00};
                coils_next = coils_reg | coil_ins[COIL_W-1:0];
            end
            KIND_CRC_LO:
            begin
                rcrc_next = {rcrc_reg[15:8], head.data};
            end
            KIND_CRC_HI:
            begin
                rcrc_next = {head.data, rcrc_reg[7:0]};
            end
            default:
            begin
            end
        endcase
    end

    // result decision in check order
    always_comb begin
        states_next = '0;
        priority if (head.is_short) begin
            status_next = ST_SHORT;
        end
        else if (slave_bad_reg) begin
            status_next = ST_WRONG_SLV;
        end
        else if (func_bad_reg) begin
            status_next = ST_WRONG_FC;
        end
        else if (head.is_trunc) begin
            status_next = ST_TRUNCATED;
        end
        else if (crc_next != rcrc_next) begin
            status_next = ST_CRC_ERR;
        end
        else begin
            status_next = ST_OK;
            states_next = coils_wide & coil_mask;
        end
    end

    // output register handshake
    always_comb begin
        out_valid_next = out_valid_reg;
        if (result.ready) begin
            out_valid_next = 1'b0;
        end
        if (pop && head.last) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            crc_reg       <= CRC_INIT;
            rcrc_reg      <= '0;
            coils_reg     <= '0;
            slave_bad_reg <= 1'b0;
            func_bad_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                if (head.last) begin
                    crc_reg       <= CRC_INIT;
                    rcrc_reg      <= '0;
                    coils_reg     <= '0;
                    slave_bad_reg <= 1'b0;
                    func_bad_reg  <= 1'b0;
                end
                else begin
                    crc_reg       <= crc_next;
                    rcrc_reg      <= rcrc_next;
                    coils_reg     <= coils_next;
                    slave_bad_reg <= slave_bad_next;
                    func_bad_reg  <= func_bad_next;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk) begin
        if (pop && head.last) begin
            status_reg <= status_next;
            states_reg <= states_next;
        end
    end

endmodule

// File: rtl/modbus_coil_reply_checker.sv
// ----------------------------------------------------------------------------
// modbus_coil_reply_checker
// checks a modbus rtu read-coils reply and reports status and coil states
// ----------------------------------------------------------------------------
// Usage:
//   byte_stream takes one reply byte per transaction, frame_end high on the
//   last byte of a frame. result gives one transaction per frame: the status
//   (ok, short, wrong slave, wrong function, truncated, crc mismatch) and the
//   coil states, zero unless the status is ok.
//   cfg_write/cfg_index/cfg_data set the expected slave address and the
//   number of coils in use; write them only while no frame is in flight.
//   Throughput is one byte per cycle while the queue has room: the front
//   classifies a byte in the cycle it arrives, the back runs the unrolled
//   crc-16 byte update combinationally. A result is registered when the back
//   pops its last byte from the queue. The two-entry queue and the result
//   register let bytes keep flowing while a result waits; with the result
//   stalled, the back holds the next final byte and the front stops once the
//   queue is full. Reset clears frame state, empties the queue and restores
//   slave address 1 and 16 coils in use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_coil_reply_checker
    import mcrc_pkg::*;
#(
    parameter int MAX_COILS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic [0:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    mcrc_byte_if.sink      byte_stream,
    mcrc_result_if.source  result
);

    localparam int COIL_W = (MAX_COILS < 16) ? MAX_COILS : 16;

    logic [7:0] slave_address_reg;
    logic [4:0] coils_in_use_reg;
    logic       push;
    logic       pop;
    logic       q_not_full;
    logic       q_not_empty;
    q_entry_t   push_entry;
    q_entry_t   head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            slave_address_reg <= 8'd1;
            coils_in_use_reg  <= 5'd16;
        end
        else if (cfg_write) begin
            unique case (cfg_index)
                CFG_SLAVE_ADDRESS: slave_address_reg <= cfg_data;
                CFG_COILS_IN_USE:  coils_in_use_reg  <= cfg_data[4:0];
                default:           slave_address_reg <= slave_address_reg;
            endcase
        end
    end

    // byte classification
    mcrc_front #(
        .COIL_W (COIL_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .slave_address (slave_address_reg),
        .byte_stream   (byte_stream),
        .q_ready       (q_not_full),
        .push          (push),
        .entry         (push_entry)
    );

    // decoupling queue
    mcrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (q_not_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    // crc, capture and result
    mcrc_back #(
        .COIL_W (COIL_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .coils_in_use (coils_in_use_reg),
        .q_valid      (q_not_empty),
        .head         (head),
        .pop          (pop),
        .result       (result)
    );

endmodule
